// ----- hw/rtl/n2a_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the number-to-ASCII formatter.
package n2a_pkg;

	localparam logic [2:0] KIND_U8    = 3'd0;
	localparam logic [2:0] KIND_S8    = 3'd1;
	localparam logic [2:0] KIND_U16   = 3'd2;
	localparam logic [2:0] KIND_S16   = 3'd3;
	localparam logic [2:0] KIND_HEX8  = 3'd4;
	localparam logic [2:0] KIND_HEX16 = 3'd5;
	localparam logic [2:0] KIND_HEX32 = 3'd6;
	localparam logic [2:0] KIND_NONE  = 3'd7;

	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_MINUS  = 8'h2D;
	localparam logic [7:0] ASCII_HEX_OF = 8'h37; // 'A' - 10

	// decimal place index; the units place follows the four subtracted places
	localparam logic [2:0] PLACE_UNITS = 3'd4;

	// one digit handed from the decimal unit to the output stage
	typedef struct packed {
		logic       valid;
		logic [3:0] digit;
		logic       last;
	} dig_t;

	function automatic logic [15:0] place_value(input logic [1:0] idx);
		logic [15:0] pv;
		case (idx)
			2'd0: pv = 16'd10000;
			2'd1: pv = 16'd1000;
			2'd2: pv = 16'd100;
			2'd3: pv = 16'd10;
			default: pv = 16'd10;
		endcase
		return pv;
	endfunction

endpackage

// ----- hw/rtl/number_to_ascii_formatter.sv -----
`timescale 1ns / 1ps
// Top level of the number-to-ASCII formatter.
//
// Usage: present kind and value with start high; the item transfers on the
// rising edge where start is high and busy is low. The block then emits the
// ASCII characters of the number, most significant first, one per strobe:
// valid is high for exactly one cycle with character and last, and the
// receiver cannot hold it off. last marks the final character.
// Kinds: 0 u8, 1 s8, 2 u16, 3 s16 decimal; 4 hex8, 5 hex16, 6 hex32. Kind 7
// transfers but emits nothing and leaves busy low.
// Latency: a '-' for a negative decimal appears the cycle after transfer.
// Hex: one character per cycle from a nibble shift register; busy stays high
// while the nibbles shift out, and the next item can transfer once it drops.
// Decimal: the digit unit subtracts one place value per cycle; busy stays
// high while it works through the ten-thousands..tens places and then the
// units place. The last strobe shows in the same cycle that busy drops,
// and the next item may transfer in that cycle.
// Reset (arst_n low) clears the sequencer and drops any number in flight.
module number_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] value,
	output logic        valid,
	output logic [7:0]  character,
	output logic        last
);
	import n2a_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEC  = 2'd1;
	localparam logic [1:0] ST_HEX  = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] hex_sr_q;   // next nibble at the top
	logic [2:0]  hex_cnt_q;  // nibbles left minus one
	logic        valid_q;
	logic [7:0]  character_q;
	logic        last_q;

	logic        accept;
	logic        is_dec;
	logic        is_hex;
	logic        neg;
	logic [7:0]  mag8;
	logic [15:0] mag16;
	logic [15:0] dec_mag;
	logic [31:0] hex_load;
	logic [2:0]  hex_cnt_load;
	logic [3:0]  nib;
	logic [7:0]  hex_char;
	dig_t        dig;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// magnitudes for the signed kinds; the most negative value wraps to itself
	// and reads correctly as unsigned
	always_comb begin
		mag8  = value[7] ? (~value[7:0] + 8'd1) : value[7:0];
		mag16 = value[15] ? (~value[15:0] + 16'd1) : value[15:0];
		is_dec       = 1'b0;
		is_hex       = 1'b0;
		neg          = 1'b0;
		dec_mag      = 16'd0;
		hex_load     = 32'd0;
		hex_cnt_load = 3'd0;
		case (kind)
			KIND_U8: begin
				is_dec  = 1'b1;
				dec_mag = {8'd0, value[7:0]};
			end
			KIND_S8: begin
				is_dec  = 1'b1;
				neg     = value[7];
				dec_mag = {8'd0, mag8};
			end
			KIND_U16: begin
				is_dec  = 1'b1;
				dec_mag = value[15:0];
			end
			KIND_S16: begin
				is_dec  = 1'b1;
				neg     = value[15];
				dec_mag = mag16;
			end
			KIND_HEX8: begin
				is_hex       = 1'b1;
				hex_load     = {value[7:0], 24'd0};
				hex_cnt_load = 3'd1;
			end
			KIND_HEX16: begin
				is_hex       = 1'b1;
				hex_load     = {value[15:0], 16'd0};
				hex_cnt_load = 3'd3;
			end
			KIND_HEX32: begin
				is_hex       = 1'b1;
				hex_load     = value;
				hex_cnt_load = 3'd7;
			end
			KIND_NONE: begin
				is_dec = 1'b0;
			end
			default: begin
				is_dec = 1'b0;
			end
		endcase
	end

	n2a_dec u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && is_dec),
		.mag    (dec_mag),
		.dig    (dig)
	);

	assign nib      = hex_sr_q[31:28];
	assign hex_char = (nib > 4'd9) ? ({4'd0, nib} + ASCII_HEX_OF) : ({4'd0, nib} + ASCII_ZERO);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hex_cnt_q <= 3'd0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && is_dec) begin
						state_q <= ST_DEC;
						valid_q <= neg;
					end else if (accept && is_hex) begin
						state_q   <= ST_HEX;
						hex_cnt_q <= hex_cnt_load;
					end
				end
				ST_DEC: begin
					valid_q <= dig.valid;
					if (dig.valid && dig.last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_HEX: begin
					valid_q   <= 1'b1;
					hex_cnt_q <= hex_cnt_q - 3'd1;
					if (hex_cnt_q == 3'd0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: nibble shift line and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			hex_sr_q    <= hex_load;
			character_q <= ASCII_MINUS;
			last_q      <= 1'b0;
		end else if (state_q == ST_HEX) begin
			hex_sr_q    <= {hex_sr_q[27:0], 4'd0};
			character_q <= hex_char;
			last_q      <= (hex_cnt_q == 3'd0);
		end else begin
			character_q <= {4'd0, dig.digit} + ASCII_ZERO;
			last_q      <= dig.last;
		end
	end

	assign valid     = valid_q;
	assign character = character_q;
	assign last      = last_q;

	// digits only come out while the sequencer waits on the decimal unit
	a_dig_in_dec: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> (state_q == ST_DEC))
		else $error("decimal digit outside decimal state");

	// a transfer of a real kind makes the block busy on the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (is_dec || is_hex)) |=> busy)
		else $error("busy did not rise after transfer");

	// finishing a number returns to idle with a strobed last character
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (valid && last))
		else $error("busy fell without a last character");

endmodule

// ----- hw/rtl/n2a_dec.sv -----
`timescale 1ns / 1ps
// Serial decimal digit generator: repeated subtraction, one step per cycle.
module n2a_dec (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [15:0]  mag,
	output n2a_pkg::dig_t dig
);
	import n2a_pkg::*;

	logic [15:0] rem_q;
	logic [2:0]  place_q;
	logic [3:0]  digit_q;
	logic        started_q;
	logic        run_q;
	logic [15:0] pv;
	logic        ge;
	logic        units;

	assign pv    = place_value(place_q[1:0]);
	assign units = (place_q == PLACE_UNITS);
	assign ge    = (rem_q >= pv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			place_q   <= 3'd0;
			digit_q   <= 4'd0;
			started_q <= 1'b0;
		end else if (start) begin
			run_q     <= 1'b1;
			place_q   <= 3'd0;
			digit_q   <= 4'd0;
			started_q <= 1'b0;
		end else if (run_q) begin
			if (units) begin
				run_q <= 1'b0;
			end else if (ge) begin
				digit_q <= digit_q + 4'd1;
			end else begin
				started_q <= started_q | (digit_q != 4'd0);
				digit_q   <= 4'd0;
				place_q   <= place_q + 3'd1;
			end
		end
	end

	// remainder is payload
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag;
		end else if (run_q && !units && ge) begin
			rem_q <= rem_q - pv;
		end
	end

	// a digit is out once its place stops subtracting; leading zeros dropped
	assign dig.valid = run_q && (units || (!ge && (started_q || digit_q != 4'd0)));
	assign dig.digit = units ? rem_q[3:0] : digit_q;
	assign dig.last  = run_q && units;

endmodule

// ----- test/n2a_checker.sv -----
`timescale 1ns / 1ps
// Checker for the number-to-ASCII formatter: predicts each character and compares.
module n2a_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] value,
	input  logic        valid,
	input  logic [7:0]  character,
	input  logic        last,
	output int          failures,
	output int          transfers,
	output int          outstanding
);
	import n2a_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} char_t;

	localparam logic [15:0] DEC_WEIGHT [4] = '{16'd10000, 16'd1000, 16'd100, 16'd10};

	char_t expected_chars[$];

	function automatic void add_char(input logic [7:0] c);
		char_t e;
		e.ch = c;
		e.fin = 1'b0;
		expected_chars.push_back(e);
	endfunction

	// leading zeros dropped, units digit always emitted
	function automatic void add_decimal(input logic [15:0] mag);
		logic [15:0] rest;
		logic [3:0]  dig;
		logic        leading;
		int          i;
		rest = mag;
		leading = 1'b1;
		for (i = 0; i < 4; i++) begin
			dig = 4'd0;
			while (rest >= DEC_WEIGHT[i]) begin
				rest -= DEC_WEIGHT[i];
				dig++;
			end
			if (!leading || dig != 4'd0) begin
				add_char(ASCII_ZERO + dig);
				leading = 1'b0;
			end
		end
		add_char(ASCII_ZERO + rest[7:0]);
	endfunction

	function automatic void add_hex(input logic [31:0] v, input int nibbles);
		logic [3:0] nib;
		int         i;
		for (i = nibbles - 1; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			add_char(nib > 4'd9 ? ASCII_HEX_OF + nib : ASCII_ZERO + nib);
		end
	endfunction

	function automatic void predict_number(input logic [2:0] k, input logic [31:0] v);
		logic [7:0]  b;
		logic [15:0] h;
		char_t       tail;
		int          first;
		first = expected_chars.size();
		b = v[7:0];
		h = v[15:0];
		case (k)
			KIND_U8: add_decimal({8'd0, b});
			KIND_S8: begin
				if (b[7]) begin
					add_char(ASCII_MINUS);
					b = -b;
				end
				add_decimal({8'd0, b});
			end
			KIND_U16: add_decimal(h);
			KIND_S16: begin
				if (h[15]) begin
					add_char(ASCII_MINUS);
					h = -h;
				end
				add_decimal(h);
			end
			KIND_HEX8:  add_hex(v, 2);
			KIND_HEX16: add_hex(v, 4);
			KIND_HEX32: add_hex(v, 8);
			default: ;
		endcase
		if (expected_chars.size() > first) begin
			tail = expected_chars.pop_back();
			tail.fin = 1'b1;
			expected_chars.push_back(tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		char_t exp_c;
		if (!arst_n) begin
			expected_chars.delete();
			failures = 0;
			transfers <= 0;
			outstanding <= 0;
		end else begin
			// check before predicting: a new transfer may share the edge of the last strobe
			if (valid) begin
				if (expected_chars.size() == 0) begin
					if (failures < 10)
						$display("unexpected char 0x%02h last %0b at %0t",
							character, last, $realtime);
					failures++;
				end else begin
					exp_c = expected_chars.pop_front();
					if (exp_c.ch !== character || exp_c.fin !== last) begin
						if (failures < 10)
							$display("mismatch: expected char 0x%02h last %0b, got 0x%02h last %0b at %0t",
								exp_c.ch, exp_c.fin, character, last, $realtime);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				predict_number(kind, value);
				transfers <= transfers + 1;
			end
			outstanding <= expected_chars.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the formatter testbench: clock, reset, stimulus and verdict.
module testbench;
	import n2a_pkg::*;

	localparam int ITEMS      = 330;  // random numbers with a real kind
	localparam int IDLE_LIMIT = 2000; // cycles with no transfer and no strobe
	localparam int DRAIN      = 40;   // longer than the slowest decimal number takes

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [31:0] value;
	logic        valid;
	logic [7:0]  character;
	logic        last;

	int failures;
	int transfers;
	int outstanding;
	int idle_cycles;

	number_to_ascii_formatter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.value     (value),
		.valid     (valid),
		.character (character),
		.last      (last)
	);

	n2a_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.value       (value),
		.valid       (valid),
		.character   (character),
		.last        (last),
		.failures    (failures),
		.transfers   (transfers),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog: a stuck handshake or a lost character stops the run here
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Present one number at the falling edge and hold it until the transfer.
	// start is left high so a following call can go back to back.
	task automatic send_number(input logic [2:0] k, input logic [31:0] v);
		int target;
		target = transfers + 1;
		start = 1'b1;
		kind = k;
		value = v;
		do @(negedge clk); while (transfers != target);
	endtask

	// Mix of full-range values, small values, sign/width corners and mid-size
	// decimals; the upper bits are random throughout so they are shown ignored.
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 3))
			0: ;
			1: v[15:0] = 16'($urandom_range(0, 20));
			2: begin
				case ($urandom_range(0, 9))
					0: v[15:0] = 16'h007F;
					1: v[15:0] = 16'h0080;
					2: v[15:0] = 16'h00FF;
					3: v[15:0] = 16'h7FFF;
					4: v[15:0] = 16'h8000;
					5: v[15:0] = 16'hFFFF;
					6: v[15:0] = 16'hFF81;
					7: v[15:0] = 16'h0000;
					8: v[15:0] = 16'd10000;
					default: v[15:0] = 16'd9999;
				endcase
			end
			default: v[15:0] = 16'($urandom_range(0, 1200));
		endcase
		return v;
	endfunction

	initial begin
		logic [2:0]  k;
		logic [31:0] v;
		int          sent;
		int          burst;

		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_U8;
		value = 32'd0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: width extremes, most negative values, zero, dropped high bits
		send_number(KIND_U8,    32'h0000_0000);
		send_number(KIND_U8,    32'h0000_00FF);
		send_number(KIND_U8,    32'hFFFF_FF00);  // high bits ignored, prints 0
		send_number(KIND_U8,    32'h0000_0064);
		send_number(KIND_U8,    32'h0000_0009);
		send_number(KIND_S8,    32'h0000_0080);  // -128
		send_number(KIND_S8,    32'h0000_007F);
		send_number(KIND_S8,    32'h0000_00FF);
		send_number(KIND_S8,    32'hFFFF_FF00);
		send_number(KIND_U16,   32'h0000_0000);
		send_number(KIND_U16,   32'h0000_FFFF);
		send_number(KIND_U16,   32'h0000_2710);  // 10000
		send_number(KIND_U16,   32'hABCD_270F);  // 9999
		send_number(KIND_S16,   32'h0000_8000);  // -32768
		send_number(KIND_S16,   32'h0000_7FFF);
		send_number(KIND_S16,   32'hFFFF_FFFF);
		send_number(KIND_S16,   32'h0000_0000);
		send_number(KIND_HEX8,  32'h1234_56AB);
		send_number(KIND_HEX16, 32'h0000_09AF);
		send_number(KIND_HEX32, 32'h0123_ABCD);
		send_number(KIND_HEX32, 32'hFFFF_FFFF);
		send_number(KIND_HEX32, 32'h0000_0000);
		send_number(KIND_NONE,  32'hDEAD_BEEF);  // no characters at all
		send_number(KIND_U8,    32'h0000_000A);

		// random: bursts of back-to-back numbers, most of them separated by random gaps
		sent = 0;
		burst = 0;
		while (sent < ITEMS) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				if ($urandom_range(0, 3) != 0) begin
					start = 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
				end
			end
			if ($urandom_range(0, 19) == 0)
				k = KIND_NONE;
			else
				k = 3'($urandom_range(0, 6));
			v = pick_value();
			send_number(k, v);
			burst--;
			if (k != KIND_NONE)
				sent++;
		end
		start = 1'b0;

		// drain, then leave room for any stray strobe to show
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		if (failures == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
